// File: hw/rtl/hdi_pkg.sv
// Shared constants and codes for the hot data identifier.
package hdi_pkg;

  // Table geometry; the entry count must stay a power of two.
  localparam int TABLE_ENTRIES = 1024;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int COUNT_W       = 16;
  localparam int TIME_W        = 32;
  localparam int ENTRY_W       = COUNT_W + TIME_W;

  // Field and register widths.
  localparam int LPN_W     = 32;
  localparam int HEAT_W    = 16;
  localparam int THR_W     = 16;
  localparam int HL_W      = 20;
  localparam int CFG_W     = 20;
  localparam int CFG_IDX_W = 1;

  // Rate compare: count scaled by 256 against threshold times age.
  localparam int RATE_SHIFT = 8;
  localparam int LHS_W      = COUNT_W + RATE_SHIFT;
  localparam int PROD_W     = THR_W + TIME_W;
  localparam int CMP_W      = (LHS_W > PROD_W) ? LHS_W : PROD_W;
  localparam logic [63:0] AGE_LIMIT = 64'd1 << 40;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Remainder unit step counter.
  localparam int STEP_W = $clog2(TIME_W);

  // Register reset values.
  localparam logic [THR_W-1:0] THR_RESET = THR_W'(128);
  localparam logic [HL_W-1:0]  HL_RESET  = HL_W'(1000);

  // Opcodes.
  localparam logic OP_ACCESS = 1'b0;
  localparam logic OP_EVICT  = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_HOT_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_LIFE     = 1'b1;

endpackage

// File: hw/rtl/hdi_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module hdi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/hdi_rem.sv
// Bit-serial remainder unit: write clock modulo half-life, one bit per cycle.
module hdi_rem
  import hdi_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [TIME_W-1:0] dividend,
  input  logic [HL_W-1:0]   divisor,
  output logic              done,
  output logic [HL_W-1:0]   rem
);

  logic [TIME_W-1:0] dvd_r;
  logic [HL_W-1:0]   rem_r;
  logic [STEP_W-1:0] step_r;
  logic              run_r;
  logic              done_r;
  logic [HL_W:0]     trial;
  logic [HL_W:0]     diff;
  logic [HL_W-1:0]   rem_nxt;

  always_comb begin
    trial   = {rem_r, dvd_r[TIME_W-1]};
    diff    = trial - {1'b0, divisor};
    rem_nxt = (trial >= {1'b0, divisor}) ? diff[HL_W-1:0] : trial[HL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r  <= 1'b1;
        step_r <= '0;
        rem_r  <= '0;
        dvd_r  <= dividend;
      end else if (run_r) begin
        // shift in one dividend bit, subtract when it fits
        rem_r  <= rem_nxt;
        dvd_r  <= dvd_r << 1;
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(TIME_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

// File: hw/rtl/hot_data_identifier.sv
// Top level of the hot data identifier: table control, decay sweep and ports.
//
//  channel  | ports                                          | beat taken when
//  ---------+------------------------------------------------+----------------------
//  input    | in_opcode in_lpn in_is_write in_cache_hit      | start && !busy
//  result   | out_hot out_heat_count                         | out_valid (one cycle)
//  config   | cfg_index cfg_wdata                            | cfg_we
//
// An evict beat writes its table entry at once and shows its result in the next cycle;
// the next beat may follow right away. An access beat runs read, multiply and
// write-back through the one table memory, in states S_READ and S_WB, before the next
// beat is taken; its result shows in the cycle after write-back. When an access is hot
// on a half-life tick the block walks all 1024 entries with busy high.
// After reset a clearing pass writes zeros to all 1024 entries, busy high meanwhile.
// A half-life write recomputes the clock phase in the remainder unit, busy high meanwhile.
// The receiver cannot stall; every result beat is taken in the cycle it shows.
module hot_data_identifier
  import hdi_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic                 in_opcode,
  input  logic [LPN_W-1:0]     in_lpn,
  input  logic                 in_is_write,
  input  logic                 in_cache_hit,
  output logic                 out_valid,
  output logic                 out_hot,
  output logic [HEAT_W-1:0]    out_heat_count,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_READ  = 6'b000100,
    S_WB    = 6'b001000,
    S_SWEEP = 6'b010000,
    S_MOD   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // Write clock and its phase within the half-life period.
  logic [TIME_W-1:0] clock_r, clock_nxt, clock_inc;
  logic [HL_W-1:0]   phase_r, phase_nxt, phase_step;
  logic [HL_W:0]     phase_inc;

  // Configuration.
  logic [THR_W-1:0] thr_r;
  logic [HL_W-1:0]  hl_r;
  logic             mod_pend_r;

  // Item being worked on.
  logic [IDX_W-1:0]   idx_r;
  logic               wr_r;
  logic               hit_r;
  logic [COUNT_W-1:0] cnt_r;
  logic [PROD_W-1:0]  prod_r;
  logic               age_big_r;

  // Clearing pass and decay sweep.
  logic [IDX_W-1:0] clr_addr_r;
  logic [IDX_W-1:0] sw_addr_r;
  logic             sw_rd_done_r;
  logic             wb_valid_r;
  logic [IDX_W-1:0] wb_addr_r;

  // Result register.
  logic              out_valid_r;
  logic              out_hot_r;
  logic [HEAT_W-1:0] out_heat_count_r;

  // Table memory: {count, touch time}.
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [IDX_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  logic              rem_start;
  logic              rem_done;
  logic [HL_W-1:0]   rem_val;

  logic               accept;
  logic               is_evict;
  logic [IDX_W-1:0]   in_idx;
  logic [COUNT_W-1:0] rd_cnt;
  logic [TIME_W-1:0]  rd_touch;
  logic [TIME_W-1:0]  age;
  logic [PROD_W-1:0]  prod;
  logic               age_big;
  logic               stale;
  logic [CMP_W-1:0]   lhs_ext;
  logic               rate_hot;
  logic               hot_calc;
  logic [COUNT_W-1:0] cnt_new;
  logic               sweep_go;

  assign busy     = (state_r != S_IDLE) || mod_pend_r;
  assign accept   = start && !busy;
  assign is_evict = (in_opcode == OP_EVICT);
  assign in_idx   = IDX_W'(in_lpn % TABLE_ENTRIES);

  hdi_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  hdi_rem u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rem_start),
    .dividend (clock_r),
    .divisor  (hl_r),
    .done     (rem_done),
    .rem      (rem_val)
  );

  // Entry fields and age, shared by the access read and the decay sweep.
  always_comb begin
    rd_cnt   = ram_rdata[ENTRY_W-1:TIME_W];
    rd_touch = ram_rdata[TIME_W-1:0];
    age      = clock_r - rd_touch;
    prod     = PROD_W'(thr_r) * PROD_W'(age);
    age_big  = 64'(age) >= AGE_LIMIT;
    stale    = 64'(age) >= 64'(hl_r);
  end

  // Classification at write-back, from the registered product.
  always_comb begin
    lhs_ext  = CMP_W'(cnt_r) << RATE_SHIFT;
    rate_hot = (thr_r == '0) || (!age_big_r && (lhs_ext > CMP_W'(prod_r)));
    if (hit_r) begin
      hot_calc = 1'b1;
    end else if (cnt_r != '0) begin
      hot_calc = rate_hot;
    end else begin
      hot_calc = wr_r;
    end
    cnt_new  = (cnt_r == COUNT_MAX) ? cnt_r : cnt_r + 1'b1;
    sweep_go = hot_calc && (hl_r != '0) && (phase_r == '0);
  end

  // Advance clock on a write; phase restarts per period and at wrap, or loads rem_val.
  always_comb begin
    clock_inc  = clock_r + 1'b1;
    phase_inc  = {1'b0, phase_r} + 1'b1;
    if (clock_inc == '0) begin
      phase_step = '0;
    end else if (phase_inc == {1'b0, hl_r}) begin
      phase_step = '0;
    end else begin
      phase_step = phase_inc[HL_W-1:0];
    end
    clock_nxt = clock_r;
    phase_nxt = phase_r;
    if (accept && !is_evict && in_is_write) begin
      clock_nxt = clock_inc;
      phase_nxt = phase_step;
    end else if (state_r == S_MOD && rem_done) begin
      phase_nxt = rem_val;
    end
  end

  // Table port steering.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = '0;
    ram_raddr = sw_addr_r;
    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_r;
      end
      S_IDLE: begin
        ram_raddr = in_idx;
        if (accept && is_evict) begin
          ram_we    = 1'b1;
          ram_waddr = in_idx;
        end
      end
      S_WB: begin
        ram_we    = 1'b1;
        ram_wdata = {cnt_new, clock_r};
      end
      S_SWEEP: begin
        // halve stale counts, keep the touch time
        ram_we    = wb_valid_r;
        ram_waddr = wb_addr_r;
        ram_wdata = {(stale ? (rd_cnt >> 1) : rd_cnt), rd_touch};
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  assign rem_start = (state_r == S_IDLE) && mod_pend_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (clr_addr_r == IDX_W'(TABLE_ENTRIES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (mod_pend_r) begin
          state_nxt = S_MOD;
        end else if (accept && !is_evict) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_WB;
      end
      S_WB: begin
        state_nxt = sweep_go ? S_SWEEP : S_IDLE;
      end
      S_SWEEP: begin
        if (sw_rd_done_r && wb_valid_r) begin
          state_nxt = S_IDLE;
        end
      end
      S_MOD: begin
        if (rem_done) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clock_r      <= '0;
      phase_r      <= '0;
      thr_r        <= THR_RESET;
      hl_r         <= HL_RESET;
      mod_pend_r   <= 1'b0;
      clr_addr_r   <= '0;
      sw_addr_r    <= '0;
      sw_rd_done_r <= 1'b0;
      wb_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clock_r <= clock_nxt;
      phase_r <= phase_nxt;

      // Configuration writes; a new half-life needs a fresh phase.
      if (cfg_we && cfg_index == REG_HOT_THRESHOLD) begin
        thr_r <= cfg_wdata[THR_W-1:0];
      end
      if (cfg_we && cfg_index == REG_HALF_LIFE) begin
        hl_r       <= cfg_wdata[HL_W-1:0];
        mod_pend_r <= 1'b1;
      end else if (rem_start) begin
        mod_pend_r <= 1'b0;
      end

      if (state_r == S_CLEAR) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end

      // Sweep: issue a read each cycle, write each entry back in the cycle after its read.
      if (state_r == S_WB) begin
        sw_addr_r    <= '0;
        sw_rd_done_r <= 1'b0;
        wb_valid_r   <= 1'b0;
      end else if (state_r == S_SWEEP) begin
        wb_valid_r <= !sw_rd_done_r;
        if (!sw_rd_done_r) begin
          sw_addr_r <= sw_addr_r + 1'b1;
          if (sw_addr_r == IDX_W'(TABLE_ENTRIES - 1)) begin
            sw_rd_done_r <= 1'b1;
          end
        end
      end

      out_valid_r <= (accept && is_evict) || (state_r == S_WB);
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      idx_r <= in_idx;
      wr_r  <= in_is_write;
      hit_r <= in_cache_hit;
    end
    if (state_r == S_READ) begin
      cnt_r     <= rd_cnt;
      prod_r    <= prod;
      age_big_r <= age_big;
    end
    if (state_r == S_SWEEP) begin
      wb_addr_r <= sw_addr_r;
    end
    if (state_r == S_WB) begin
      out_hot_r        <= hot_calc;
      out_heat_count_r <= HEAT_W'(cnt_new);
    end else begin
      out_hot_r        <= 1'b0;
      out_heat_count_r <= '0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hot        = out_hot_r;
  assign out_heat_count = out_heat_count_r;

endmodule

// File: hw/rtl/hdi_chk.sv
// Port-level checker for the hot data identifier, bound to the top level.
module hdi_chk
  import hdi_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 start,
  input logic                 busy,
  input logic                 in_opcode,
  input logic [LPN_W-1:0]     in_lpn,
  input logic                 in_is_write,
  input logic                 in_cache_hit,
  input logic                 out_valid,
  input logic                 out_hot,
  input logic [HEAT_W-1:0]    out_heat_count,
  input logic                 cfg_we,
  input logic [CFG_IDX_W-1:0] cfg_index,
  input logic [CFG_W-1:0]     cfg_wdata
);

  // Reset starts the clearing pass.
  assert property (@(posedge clk) !rst_n |=> busy)
    else $error("busy low right after reset");

  // An evict answers cold with a zero count in the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_opcode == OP_EVICT |=> out_valid && !out_hot && out_heat_count == '0)
    else $error("evict result wrong or missing");

  // An access holds the block busy while the entry is read.
  assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_opcode == OP_ACCESS |=> busy && !out_valid)
    else $error("access did not hold busy");

  // A cache hit is always hot, the result showing after the read and write-back states.
  assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_opcode == OP_ACCESS && in_cache_hit |=> ##2 out_valid && out_hot)
    else $error("hit not reported hot");

  // A zero count only comes from an evict, which is cold.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_heat_count == '0 |-> !out_hot)
    else $error("hot result with zero count");

endmodule

bind hot_data_identifier hdi_chk u_hdi_chk (.*);

// File: tb/hdi_tb_pkg.sv
// Hotness predictor and result board for the hot data identifier testbench.
`timescale 1ns / 1ps
package hdi_tb_pkg;
  import hdi_pkg::*;

  typedef struct packed {
    logic              hot;
    logic [HEAT_W-1:0] heat_count;
  } heat_beat_t;

  class hotness_board;
    logic [COUNT_W-1:0] access_cnt  [TABLE_ENTRIES];
    logic [TIME_W-1:0]  touch_stamp [TABLE_ENTRIES];
    logic [TIME_W-1:0]  write_clock;
    logic [THR_W-1:0]   hot_threshold;
    logic [HL_W-1:0]    half_life;
    heat_beat_t         pending_heat [$];
    int unsigned        mismatches;
    int unsigned        results_seen;

    function new();
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        access_cnt[i]  = '0;
        touch_stamp[i] = '0;
      end
      write_clock   = '0;
      hot_threshold = THR_RESET;
      half_life     = HL_RESET;
      mismatches    = 0;
      results_seen  = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
      case (idx)
        REG_HOT_THRESHOLD: hot_threshold = value[THR_W-1:0];
        REG_HALF_LIFE:     half_life     = value[HL_W-1:0];
        default: ;
      endcase
    endfunction

    // Ages stay below 2^40 with a 32-bit clock, so only the product compare matters.
    function bit rate_hot(logic [COUNT_W-1:0] count, logic [TIME_W-1:0] age);
      logic [63:0] scaled;
      logic [63:0] budget;
      if (hot_threshold == '0) return 1'b1;
      scaled = 64'(count) << RATE_SHIFT;
      budget = 64'(hot_threshold) * 64'(age);
      return scaled > budget;
    endfunction

    // Halve every entry untouched for at least a half-life.
    function void decay_stale();
      logic [TIME_W-1:0] age;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        age = write_clock - touch_stamp[i];
        if (age >= TIME_W'(half_life)) access_cnt[i] = access_cnt[i] >> 1;
      end
    endfunction

    // Classify one accepted beat and queue the heat it must produce.
    function void classify_access(logic op, logic [LPN_W-1:0] lpn, logic wr, logic hit);
      logic [IDX_W-1:0]   idx;
      logic [COUNT_W-1:0] cnt;
      logic               hot;
      heat_beat_t         heat;
      idx = lpn[IDX_W-1:0];
      if (op == OP_EVICT) begin
        access_cnt[idx]  = '0;
        touch_stamp[idx] = '0;
        heat = '{hot: 1'b0, heat_count: '0};
        pending_heat.push_back(heat);
        return;
      end
      if (wr) write_clock = write_clock + 1'b1;
      cnt = access_cnt[idx];
      if (hit)
        hot = 1'b1;
      else if (cnt != '0)
        hot = rate_hot(cnt, write_clock - touch_stamp[idx]);
      else
        hot = wr;
      if (cnt != COUNT_MAX) cnt = cnt + 1'b1;
      access_cnt[idx]  = cnt;
      touch_stamp[idx] = write_clock;
      if (hot && half_life != '0 && (write_clock % TIME_W'(half_life)) == '0)
        decay_stale();
      heat = '{hot: hot, heat_count: HEAT_W'(access_cnt[idx])};
      pending_heat.push_back(heat);
    endfunction

    function void compare_heat(logic hot, logic [HEAT_W-1:0] heat_count);
      heat_beat_t want;
      results_seen++;
      if (pending_heat.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d with no beat outstanding: hot=%0b count=%0d",
                   results_seen, hot, heat_count);
        return;
      end
      want = pending_heat.pop_front();
      if (hot !== want.hot || heat_count !== want.heat_count) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d mismatch: expected hot=%0b count=%0d, got hot=%0b count=%0d",
                   results_seen, want.hot, want.heat_count, hot, heat_count);
      end
    endfunction

    function int outstanding();
      return pending_heat.size();
    endfunction
  endclass

endpackage

// File: tb/tb_hot_data_identifier.sv
// Top-level testbench for the hot data identifier: stimulus, checking and verdict.
`timescale 1ns / 1ps
module tb_hot_data_identifier;
  import hdi_pkg::*;
  import hdi_tb_pkg::*;

  localparam int POOL_SIZE = 32;

  // All block inputs start at known values.
  logic                 clk          = 1'b0;
  logic                 rst_n        = 1'b0;
  logic                 start        = 1'b0;
  logic                 in_opcode    = OP_ACCESS;
  logic [LPN_W-1:0]     in_lpn       = '0;
  logic                 in_is_write  = 1'b0;
  logic                 in_cache_hit = 1'b0;
  logic                 cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index    = REG_HOT_THRESHOLD;
  logic [CFG_W-1:0]     cfg_wdata    = '0;
  logic                 busy;
  logic                 out_valid;
  logic                 out_hot;
  logic [HEAT_W-1:0]    out_heat_count;

  hotness_board heat_board = new();

  // Hot set of table indexes for the random part, so counts build up and age.
  logic [IDX_W-1:0] lpn_pool [POOL_SIZE];

  always #10 clk = ~clk;

  hot_data_identifier DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_opcode      (in_opcode),
    .in_lpn         (in_lpn),
    .in_is_write    (in_is_write),
    .in_cache_hit   (in_cache_hit),
    .out_valid      (out_valid),
    .out_hot        (out_hot),
    .out_heat_count (out_heat_count),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  // Take every result beat in the cycle it shows; values seen here are pre-edge.
  always @(posedge clk) begin
    if (rst_n && out_valid) heat_board.compare_heat(out_hot, out_heat_count);
  end

  // Present one beat and hold it until the block takes it (start high, busy low).
  // Start stays high on return: the caller either presents the next beat in the
  // same step or drops start before letting a clock edge pass.
  task automatic send_beat(input logic op, input logic [LPN_W-1:0] lpn,
                           input logic wr, input logic hit);
    start        <= 1'b1;
    in_opcode    <= op;
    in_lpn       <= lpn;
    in_is_write  <= wr;
    in_cache_hit <= hit;
    do @(posedge clk); while (busy);
    heat_board.classify_access(op, lpn, wr, hit);
  endtask

  // Drop start and wait until every result is back and the block has stayed idle
  // without a break, as counted by quiet (covers a decay sweep after the last result).
  task automatic settle();
    int quiet;
    quiet = 0;
    start <= 1'b0;
    while (quiet < 4) begin
      @(posedge clk);
      if (heat_board.outstanding() == 0 && !busy) quiet++;
      else quiet = 0;
    end
  endtask

  // Write one register with the block quiet, then mirror it in the predictor.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    heat_board.set_reg(idx, value);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [THR_W-1:0] thr;
    logic [HL_W-1:0]  hl;
    int               idle_pct;
    int               beats;
    int               gap;
    logic             op;
    logic             wr;
    logic             hit;
    logic [LPN_W-1:0] lpn;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed beats under reset register values first. Start waits out the
    // clearing pass on its own since the block holds busy high.
    send_beat(OP_ACCESS, 32'h0000_0000, 1'b0, 1'b0);  // read miss, empty entry: cold
    send_beat(OP_ACCESS, 32'h0000_0401, 1'b1, 1'b0);  // write miss, empty entry: hot
    send_beat(OP_ACCESS, 32'hFFFF_FFFF, 1'b0, 1'b1);  // hit on the last entry
    send_beat(OP_ACCESS, 32'h0000_0000, 1'b0, 1'b0);  // rate compare passes
    send_beat(OP_EVICT,  32'h0000_0000, 1'b1, 1'b1);  // evict ignores write and hit
    send_beat(OP_ACCESS, 32'h0000_0400, 1'b0, 1'b0);  // alias of a cleared entry
    repeat (4) send_beat(OP_ACCESS, 32'h5555_5555, 1'b1, 1'b0);
    send_beat(OP_ACCESS, 32'h0000_0400, 1'b0, 1'b0);  // aged entry fails the rate
    send_beat(OP_ACCESS, 32'hAAAA_AAAA, 1'b1, 1'b1);
    send_beat(OP_ACCESS, 32'hAAAA_AAAA, 1'b0, 1'b0);  // zero age on a miss: hot

    // Zero threshold makes every miss on a live entry hot.
    write_reg(REG_HOT_THRESHOLD, CFG_W'(0));
    send_beat(OP_ACCESS, 32'h0000_0400, 1'b0, 1'b0);
    write_reg(REG_HOT_THRESHOLD, CFG_W'(16'hFFFF));
    send_beat(OP_ACCESS, 32'h0000_0401, 1'b0, 1'b0);

    // Half-life of one sweeps on every hot beat; zero never sweeps.
    write_reg(REG_HALF_LIFE, CFG_W'(1));
    send_beat(OP_ACCESS, 32'h5555_5555, 1'b1, 1'b1);
    send_beat(OP_ACCESS, 32'hFFFF_FFFF, 1'b0, 1'b1);
    write_reg(REG_HALF_LIFE, CFG_W'(0));
    send_beat(OP_ACCESS, 32'h5555_5555, 1'b1, 1'b1);
    send_beat(OP_ACCESS, 32'h5555_5555, 1'b0, 1'b0);
    write_reg(REG_HALF_LIFE, CFG_W'(1000000));
    write_reg(REG_HOT_THRESHOLD, CFG_W'(1));
    send_beat(OP_ACCESS, 32'h0000_0400, 1'b1, 1'b0);
    send_beat(OP_EVICT,  32'hFFFF_FFFF, 1'b0, 1'b0);

    // Random phases, each with its own register setting and sender idling.
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin thr = THR_W'(128); hl = HL_W'(1000); idle_pct = 0; beats = 300; end
        1: begin thr = THR_W'(1); hl = HL_W'(7); idle_pct = 62; beats = 250; end
        2: begin thr = 16'hFFFF; hl = HL_W'(64); idle_pct = 0; beats = 200; end
        3: begin
          thr = THR_W'($urandom_range(4096, 1));
          hl  = HL_W'($urandom_range(200, 8));
          idle_pct = 36; beats = 300;
        end
        4: begin thr = THR_W'(200); hl = HL_W'(1); idle_pct = 0; beats = 40; end
        5: begin
          thr = THR_W'($urandom_range(65535, 1));
          hl  = HL_W'(1000000);
          idle_pct = 62; beats = 260;
        end
        6: begin thr = THR_W'(32); hl = HL_W'(16); idle_pct = 36; beats = 250; end
        default: begin
          thr = THR_W'($urandom_range(65535, 1));
          hl  = HL_W'($urandom_range(50, 4));
          idle_pct = 0; beats = 250;
        end
      endcase
      write_reg(REG_HOT_THRESHOLD, CFG_W'(thr));
      write_reg(REG_HALF_LIFE, CFG_W'(hl));

      // Refresh the hot index set; keep both ends of the table in it.
      for (int i = 0; i < POOL_SIZE; i++) lpn_pool[i] = IDX_W'($urandom());
      lpn_pool[0] = '0;
      lpn_pool[1] = '1;

      for (int n = 0; n < beats; n++) begin
        // Now and then hold off until the block has drained completely.
        if ($urandom_range(63) == 0) settle();

        // Idle for a geometric run of cycles at this phase's rate.
        gap = 0;
        while ($urandom_range(99) < idle_pct) gap++;
        if (gap > 0) begin
          start <= 1'b0;
          repeat (gap) @(posedge clk);
        end

        op  = ($urandom_range(99) < 8) ? OP_EVICT : OP_ACCESS;
        wr  = 1'($urandom_range(1));
        hit = ($urandom_range(99) < 30);
        lpn = $urandom();
        // Mostly reuse hot indexes under random upper bits so entries alias.
        if ($urandom_range(99) < 85) lpn[IDX_W-1:0] = lpn_pool[$urandom_range(POOL_SIZE - 1)];
        send_beat(op, lpn, wr, hit);
      end
    end

    // Drain, then watch long enough to catch a stray beat after a final sweep.
    settle();
    repeat (1100) @(posedge clk);
    if (heat_board.mismatches == 0 && heat_board.outstanding() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  // Hard stop well past the slowest correct run.
  initial begin
    #(64'd400_000_000);
    $display("Verification failed");
    $finish;
  end

endmodule
